### rtl/core/rmss_pkg.sv
// Package for the RGB matrix subframe scanner: sizes, codes and the
// subframe descriptor passed between the scan control and the top level.
// No dependencies.
`default_nettype none

package rmss_pkg;

    localparam int KEY_ROWS     = 5;
    localparam int COLUMNS      = 16;
    localparam int COLORS       = 3;
    localparam int FLASH_SWEEPS = 200;

    localparam int SCAN_ROWS    = KEY_ROWS + 1;
    localparam int FB_ROWS      = SCAN_ROWS * COLORS;
    localparam int FB_ADDR_W    = $clog2(FB_ROWS);
    localparam int SWEEP_LEN    = SCAN_ROWS * COLUMNS;
    localparam int MAIN_POINT   = KEY_ROWS * COLUMNS;
    localparam int SWEEP_W      = $clog2(SWEEP_LEN + 1);

    localparam int ROW_W        = 3;
    localparam int COLOR_W      = 2;
    localparam int COL_W        = 4;
    localparam int DUTY_W       = 8;
    localparam int PHASE_W      = 8;
    localparam int SPEED_W      = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_W        = 5;
    localparam int FB_ROW_BITS  = COLUMNS * DUTY_W;
    localparam int HALF_BITS    = FB_ROW_BITS / 2;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FLASH = 2'd2
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] REG_MAIN_ENABLED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_SPEED      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNDERGLOW_SPEED = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0]   sink_row;
        logic [COLOR_W-1:0] sink_color;
        logic               drive;
        logic               wrapped;
        logic [PHASE_W-1:0] main_phase;
        logic [PHASE_W-1:0] underglow_phase;
        logic               main_adv;
        logic               underglow_adv;
        logic               flash_active;
        logic [PHASE_W-1:0] pulse;
    } scan_info_t;

endpackage

`default_nettype wire

### rtl/core/rgb_matrix_subframe_scanner.sv
// Top level of the RGB matrix subframe scanner: input decode, framebuffer
// read pipeline and output register. Depends on rmss_pkg, rmss_scan_ctrl
// and rmss_frame_store.
//
//  Channel   Handshake                  Payload
//  item      item_valid / item_ready    kind, write_row, write_color, write_column, write_value
//  result    result_valid / result_ready sink_row .. status_pulse (scan ticks only)
//  config    cfg_write                  cfg_index, cfg_data
//
// One word is accepted per cycle while item_ready is high; a scan tick's result is registered
// in the read stage and then in the output register. The rate is set by the single framebuffer
// read port, read once per tick. After reset the framebuffer is cleared, one row per cycle;
// item_ready stays low until the pass is done.
// A stalled result holds in the output register while one more tick waits in the read stage.
`default_nettype none

module rgb_matrix_subframe_scanner
    import rmss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic [1:0]           kind,
    input  wire logic [ROW_W-1:0]     write_row,
    input  wire logic [COLOR_W-1:0]   write_color,
    input  wire logic [COL_W-1:0]     write_column,
    input  wire logic [DUTY_W-1:0]    write_value,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic      [ROW_W-1:0]     sink_row,
    output logic      [COLOR_W-1:0]   sink_color,
    output logic                      lit,
    output logic      [HALF_BITS-1:0] duties_low,
    output logic      [HALF_BITS-1:0] duties_high,
    output logic                      scan_wrap,
    output logic      [PHASE_W-1:0]   main_phase_out,
    output logic      [PHASE_W-1:0]   underglow_phase_out,
    output logic                      main_advanced,
    output logic                      underglow_advanced,
    output logic                      battery_flash_active,
    output logic      [PHASE_W-1:0]   status_pulse,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic                   accept;
    logic                   tick;
    logic                   flash;
    logic                   wr_en;
    logic                   fs_busy;
    logic [FB_ADDR_W-1:0]   rd_addr;
    logic [FB_ROW_BITS-1:0] rd_data;
    scan_info_t             info;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    scan_info_t             s1_info_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    scan_info_t             out_info_reg;
    logic [FB_ROW_BITS-1:0] out_duties_reg;
    logic                   out_lit_reg;
    logic                   out_free;
    logic                   s1_move;

    assign out_free   = !out_valid_reg || result_ready;
    assign s1_move    = s1_valid_reg && out_free;
    assign item_ready = !fs_busy && (!s1_valid_reg || s1_move);
    assign accept     = item_valid && item_ready;
    assign tick       = accept && (kind == KIND_TICK);
    assign flash      = accept && (kind == KIND_FLASH);
    assign wr_en      = accept && (kind == KIND_WRITE);

    rmss_scan_ctrl u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .flash     (flash),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_addr   (rd_addr),
        .info      (info)
    );

    rmss_frame_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_row    (write_row),
        .wr_color  (write_color),
        .wr_column (write_column),
        .wr_value  (write_value),
        .rd_en     (tick),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .busy      (fs_busy)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tick)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            s1_info_reg <= info;
        end
        if (s1_move)
        begin
            out_info_reg   <= s1_info_reg;
            out_duties_reg <= s1_info_reg.drive ? rd_data : '0;
            out_lit_reg    <= s1_info_reg.drive && (rd_data != '0);
        end
    end

    assign result_valid         = out_valid_reg;
    assign sink_row             = out_info_reg.sink_row;
    assign sink_color           = out_info_reg.sink_color;
    assign lit                  = out_lit_reg;
    assign duties_low           = out_duties_reg[HALF_BITS-1:0];
    assign duties_high          = out_duties_reg[FB_ROW_BITS-1:HALF_BITS];
    assign scan_wrap            = out_info_reg.wrapped;
    assign main_phase_out       = out_info_reg.main_phase;
    assign underglow_phase_out  = out_info_reg.underglow_phase;
    assign main_advanced        = out_info_reg.main_adv;
    assign underglow_advanced   = out_info_reg.underglow_adv;
    assign battery_flash_active = out_info_reg.flash_active;
    assign status_pulse         = out_info_reg.pulse;

endmodule

`default_nettype wire

### rtl/core/rmss_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module rmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 18
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/rmss_frame_store.sv
// Framebuffer: one RAM per column, each RAM address holding one row and color.
// Runs a clearing pass after reset. Depends on rmss_pkg and rmss_ram.
`default_nettype none

module rmss_frame_store
    import rmss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [ROW_W-1:0]       wr_row,
    input  wire logic [COLOR_W-1:0]     wr_color,
    input  wire logic [COL_W-1:0]       wr_column,
    input  wire logic [DUTY_W-1:0]      wr_value,
    input  wire logic                   rd_en,
    input  wire logic [FB_ADDR_W-1:0]   rd_addr,
    output logic      [FB_ROW_BITS-1:0] rd_data,
    output logic                        busy
);

    logic                 clr_active_reg;
    logic                 clr_active_next;
    logic [FB_ADDR_W-1:0] clr_addr_reg;
    logic [FB_ADDR_W-1:0] clr_addr_next;
    logic                 wr_ok;
    logic [FB_ADDR_W-1:0] wr_addr;
    logic [FB_ADDR_W-1:0] ram_waddr;
    logic [DUTY_W-1:0]    ram_wdata;
    logic [COLUMNS-1:0]   ram_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == FB_ADDR_W'(FB_ROWS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    assign wr_ok   = wr_en && (int'(wr_row) < SCAN_ROWS) && (int'(wr_color) < COLORS);
    assign wr_addr = FB_ADDR_W'(int'(wr_row) * COLORS + int'(wr_color));

    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
            ram_we    = '1;
        end
        else
        begin
            ram_waddr = wr_addr;
            ram_wdata = wr_value;
            ram_we    = wr_ok ? (COLUMNS'(1) << wr_column) : '0;
        end
    end

    for (genvar c = 0; c < COLUMNS; c++)
    begin : g_col
        rmss_ram #(
            .WIDTH (DUTY_W),
            .DEPTH (FB_ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[c]),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (rd_en),
            .raddr (rd_addr),
            .rdata (rd_data[c*DUTY_W +: DUTY_W])
        );
    end

    assign busy = clr_active_reg;

endmodule

`default_nettype wire

### rtl/core/rmss_scan_ctrl.sv
// Scan position, sweep counter, animation phases, flash countdown and the
// configuration registers. Depends on rmss_pkg.
`default_nettype none

module rmss_scan_ctrl
    import rmss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 tick,
    input  wire logic                 flash,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic      [FB_ADDR_W-1:0] rd_addr,
    output scan_info_t                info
);

    logic               main_enabled_reg;
    logic [SPEED_W-1:0] main_speed_reg;
    logic [SPEED_W-1:0] underglow_speed_reg;
    logic [ROW_W-1:0]   scan_row_reg;
    logic [ROW_W-1:0]   scan_row_next;
    logic [COLOR_W-1:0] scan_color_reg;
    logic [COLOR_W-1:0] scan_color_next;
    logic [SWEEP_W-1:0] sweep_reg;
    logic [SWEEP_W-1:0] sweep_next;
    logic [PHASE_W-1:0] main_phase_reg;
    logic [PHASE_W-1:0] main_phase_next;
    logic [PHASE_W-1:0] ug_phase_reg;
    logic [PHASE_W-1:0] ug_phase_next;
    logic [PHASE_W-1:0] flash_reg;
    logic [PHASE_W-1:0] flash_next;
    logic [PHASE_W-1:0] pulse_reg;
    logic [PHASE_W-1:0] pulse_next;
    logic [SWEEP_W-1:0] sweep_inc;
    logic               main_adv;
    logic               ug_adv;
    logic               wrapped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_enabled_reg    <= 1'b1;
            main_speed_reg      <= SPEED_W'(4);
            underglow_speed_reg <= SPEED_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAIN_ENABLED:    main_enabled_reg    <= cfg_data[0];
                REG_MAIN_SPEED:      main_speed_reg      <= cfg_data;
                REG_UNDERGLOW_SPEED: underglow_speed_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg   <= '0;
            scan_color_reg <= '0;
            sweep_reg      <= '0;
            main_phase_reg <= '0;
            ug_phase_reg   <= '0;
            flash_reg      <= '0;
            pulse_reg      <= '0;
        end
        else
        begin
            scan_row_reg   <= scan_row_next;
            scan_color_reg <= scan_color_next;
            sweep_reg      <= sweep_next;
            main_phase_reg <= main_phase_next;
            ug_phase_reg   <= ug_phase_next;
            flash_reg      <= flash_next;
            pulse_reg      <= pulse_next;
        end
    end

    always_comb
    begin
        sweep_inc       = sweep_reg + 1'b1;
        main_adv        = 1'b0;
        ug_adv          = 1'b0;
        wrapped         = 1'b0;
        sweep_next      = sweep_inc;
        main_phase_next = main_phase_reg;
        ug_phase_next   = ug_phase_reg;
        flash_next      = flash_reg;
        pulse_next      = pulse_reg;
        scan_row_next   = scan_row_reg;
        scan_color_next = scan_color_reg + 1'b1;

        if (int'(sweep_inc) >= SWEEP_LEN)
        begin
            ug_adv        = 1'b1;
            sweep_next    = '0;
            ug_phase_next = ug_phase_reg + PHASE_W'(underglow_speed_reg);
            pulse_next    = pulse_reg + 1'b1;
            if (flash_reg != '0)
            begin
                flash_next = flash_reg - 1'b1;
            end
        end
        else if (int'(sweep_inc) == MAIN_POINT)
        begin
            main_adv        = 1'b1;
            main_phase_next = main_phase_reg + PHASE_W'(main_speed_reg);
        end

        if (int'(scan_color_reg) >= COLORS - 1)
        begin
            scan_color_next = '0;
            if (int'(scan_row_reg) >= SCAN_ROWS - 1)
            begin
                scan_row_next = '0;
                wrapped       = 1'b1;
            end
            else
            begin
                scan_row_next = scan_row_reg + 1'b1;
            end
        end

        info.sink_row        = scan_row_reg;
        info.sink_color      = scan_color_reg;
        info.drive           = (int'(scan_row_reg) >= KEY_ROWS) || main_enabled_reg;
        info.wrapped         = wrapped;
        info.main_phase      = main_phase_next;
        info.underglow_phase = ug_phase_next;
        info.main_adv        = main_adv;
        info.underglow_adv   = ug_adv;
        info.flash_active    = (flash_next != '0);
        info.pulse           = pulse_next;

        if (!tick)
        begin
            sweep_next      = sweep_reg;
            main_phase_next = main_phase_reg;
            ug_phase_next   = ug_phase_reg;
            flash_next      = flash_reg;
            pulse_next      = pulse_reg;
            scan_row_next   = scan_row_reg;
            scan_color_next = scan_color_reg;
        end
        if (flash)
        begin
            flash_next = PHASE_W'(FLASH_SWEEPS);
        end
    end

    assign rd_addr = FB_ADDR_W'(int'(scan_row_reg) * COLORS + int'(scan_color_reg));

endmodule

`default_nettype wire

### rtl/core/rmss_checker.sv
// Port-level checks for the RGB matrix subframe scanner, bound to the top level.
// Depends on rmss_pkg.
`default_nettype none

module rmss_checker
    import rmss_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire logic [ROW_W-1:0]     sink_row,
    input wire logic [COLOR_W-1:0]   sink_color,
    input wire logic                 lit,
    input wire logic [HALF_BITS-1:0] duties_low,
    input wire logic [HALF_BITS-1:0] duties_high,
    input wire logic                 scan_wrap,
    input wire logic                 main_advanced,
    input wire logic                 underglow_advanced
);

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(duties_low)
            && $stable(duties_high) && $stable(sink_row))
        else $error("stalled result word changed");

    a_lit_matches_duties: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (lit == ((duties_low != '0) || (duties_high != '0))))
        else $error("lit flag disagrees with the duties");

    a_wrap_at_last_sink: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && scan_wrap |-> (int'(sink_row) == KEY_ROWS)
            && (int'(sink_color) == COLORS - 1))
        else $error("frame wrap flagged away from the last sink");

    a_single_advance: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(main_advanced && underglow_advanced))
        else $error("main and underglow advanced on the same tick");

endmodule

bind rgb_matrix_subframe_scanner rmss_checker u_rmss_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .sink_row           (sink_row),
    .sink_color         (sink_color),
    .lit                (lit),
    .duties_low         (duties_low),
    .duties_high        (duties_high),
    .scan_wrap          (scan_wrap),
    .main_advanced      (main_advanced),
    .underglow_advanced (underglow_advanced)
);

`default_nettype wire

### verif/rmss_tb_pkg.sv
// Scoreboard for the RGB matrix subframe scanner testbench. It mirrors the
// scanner's framebuffer, scan position and animation counters.
// Depends on rmss_pkg for sizes, item kinds and register indexes.
package rmss_tb_pkg;

    import rmss_pkg::*;

    localparam logic [1:0]         KIND_IGNORED = 2'd3;
    localparam logic [COLOR_W-1:0] BAD_COLOR    = 2'd3;
    localparam int                 REPORT_MAX   = 10;

    typedef struct packed {
        logic [ROW_W-1:0]     sink_row;
        logic [COLOR_W-1:0]   sink_color;
        logic                 lit;
        logic [HALF_BITS-1:0] duties_low;
        logic [HALF_BITS-1:0] duties_high;
        logic                 scan_wrap;
        logic [PHASE_W-1:0]   main_phase;
        logic [PHASE_W-1:0]   underglow_phase;
        logic                 main_adv;
        logic                 underglow_adv;
        logic                 flash_active;
        logic [PHASE_W-1:0]   pulse;
    } scan_word_t;

    class rmss_scoreboard;

        bit [DUTY_W-1:0]  pixels [SCAN_ROWS][COLORS][COLUMNS];
        bit               keys_on;
        bit [SPEED_W-1:0] main_step;
        bit [SPEED_W-1:0] glow_step;
        int               sweep_pos;
        bit [ROW_W-1:0]   row_now;
        bit [COLOR_W-1:0] color_now;
        bit [PHASE_W-1:0] main_angle;
        bit [PHASE_W-1:0] glow_angle;
        bit [PHASE_W-1:0] flash_left;
        bit [PHASE_W-1:0] pulse_count;
        scan_word_t       subframes_due [$];
        int               failures;

        function new();
            foreach (pixels[r, c, x])
                pixels[r][c][x] = '0;
            keys_on = 1'b1;
            main_step = 5'd4;
            glow_step = 5'd1;
            sweep_pos = 0;
            row_now = '0;
            color_now = '0;
            main_angle = '0;
            glow_angle = '0;
            flash_left = '0;
            pulse_count = '0;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_MAIN_ENABLED:    keys_on = data[0];
                REG_MAIN_SPEED:      main_step = data;
                REG_UNDERGLOW_SPEED: glow_step = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return subframes_due.size();
        endfunction

        // Notes one accepted input word; a scan tick queues the subframe it yields.
        function void note_item(logic [1:0] k, logic [ROW_W-1:0] r, logic [COLOR_W-1:0] c,
                                logic [COL_W-1:0] x, logic [DUTY_W-1:0] v);
            scan_word_t   want;
            bit [DUTY_W-1:0] any;
            case (k)
                KIND_WRITE:
                    if (r < SCAN_ROWS && c < COLORS)
                        pixels[r][c][x] = v;
                KIND_FLASH:
                    flash_left = PHASE_W'(FLASH_SWEEPS);
                KIND_TICK:
                begin
                    want = '0;
                    sweep_pos++;
                    if (sweep_pos >= SWEEP_LEN) begin
                        sweep_pos = 0;
                        glow_angle = glow_angle + PHASE_W'(glow_step);
                        if (flash_left != 0)
                            flash_left--;
                        pulse_count++;
                        want.underglow_adv = 1'b1;
                    end
                    else if (sweep_pos == MAIN_POINT) begin
                        main_angle = main_angle + PHASE_W'(main_step);
                        want.main_adv = 1'b1;
                    end
                    if (row_now >= KEY_ROWS || keys_on) begin
                        any = '0;
                        for (int i = 0; i < COLUMNS / 2; i++) begin
                            want.duties_low[DUTY_W*i +: DUTY_W] = pixels[row_now][color_now][i];
                            want.duties_high[DUTY_W*i +: DUTY_W] =
                                pixels[row_now][color_now][i + COLUMNS / 2];
                            any = any | pixels[row_now][color_now][i]
                                      | pixels[row_now][color_now][i + COLUMNS / 2];
                        end
                        want.lit = (any != 0);
                    end
                    want.sink_row = row_now;
                    want.sink_color = color_now;
                    color_now++;
                    if (color_now >= COLORS) begin
                        color_now = '0;
                        row_now++;
                        if (row_now >= SCAN_ROWS) begin
                            row_now = '0;
                            want.scan_wrap = 1'b1;
                        end
                    end
                    want.main_phase = main_angle;
                    want.underglow_phase = glow_angle;
                    want.flash_active = (flash_left != 0);
                    want.pulse = pulse_count;
                    subframes_due.push_back(want);
                end
                default: ;
            endcase
        endfunction

        function void check_result(scan_word_t got);
            scan_word_t want;
            if (subframes_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("Unexpected result word: %p", got);
                return;
            end
            want = subframes_due.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("Result mismatch: expected %p, got %p", want, got);
            end
        endfunction

    endclass

endpackage

### verif/tb_rgb_matrix_subframe_scanner.sv
// Top level of the RGB matrix subframe scanner testbench: clock, reset,
// drivers, monitor and watchdog. Depends on rmss_pkg, rmss_tb_pkg and the RTL.
module tb_rgb_matrix_subframe_scanner;

    import rmss_pkg::*;
    import rmss_tb_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 270;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    logic [1:0]           kind;
    logic [ROW_W-1:0]     write_row;
    logic [COLOR_W-1:0]   write_color;
    logic [COL_W-1:0]     write_column;
    logic [DUTY_W-1:0]    write_value;
    logic                 result_valid;
    logic                 result_ready;
    logic [ROW_W-1:0]     sink_row;
    logic [COLOR_W-1:0]   sink_color;
    logic                 lit;
    logic [HALF_BITS-1:0] duties_low;
    logic [HALF_BITS-1:0] duties_high;
    logic                 scan_wrap;
    logic [PHASE_W-1:0]   main_phase_out;
    logic [PHASE_W-1:0]   underglow_phase_out;
    logic                 main_advanced;
    logic                 underglow_advanced;
    logic                 battery_flash_active;
    logic [PHASE_W-1:0]   status_pulse;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rmss_scoreboard sb = new();
    int send_gap_pct;
    int recv_stall_pct;
    int idle_cycles = 0;

    rgb_matrix_subframe_scanner i_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item_valid           (item_valid),
        .item_ready           (item_ready),
        .kind                 (kind),
        .write_row            (write_row),
        .write_color          (write_color),
        .write_column         (write_column),
        .write_value          (write_value),
        .result_valid         (result_valid),
        .result_ready         (result_ready),
        .sink_row             (sink_row),
        .sink_color           (sink_color),
        .lit                  (lit),
        .duties_low           (duties_low),
        .duties_high          (duties_high),
        .scan_wrap            (scan_wrap),
        .main_phase_out       (main_phase_out),
        .underglow_phase_out  (underglow_phase_out),
        .main_advanced        (main_advanced),
        .underglow_advanced   (underglow_advanced),
        .battery_flash_active (battery_flash_active),
        .status_pulse         (status_pulse),
        .cfg_write            (cfg_write),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        scan_word_t got;
        if (rst_n) begin
            if (result_valid && result_ready) begin
                got.sink_row = sink_row;
                got.sink_color = sink_color;
                got.lit = lit;
                got.duties_low = duties_low;
                got.duties_high = duties_high;
                got.scan_wrap = scan_wrap;
                got.main_phase = main_phase_out;
                got.underglow_phase = underglow_phase_out;
                got.main_adv = main_advanced;
                got.underglow_adv = underglow_advanced;
                got.flash_active = battery_flash_active;
                got.pulse = status_pulse;
                sb.check_result(got);
            end
            if (item_valid && item_ready)
                sb.note_item(kind, write_row, write_color, write_column, write_value);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL rgb_matrix_subframe_scanner");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] k, input logic [ROW_W-1:0] r,
                             input logic [COLOR_W-1:0] c, input logic [COL_W-1:0] x,
                             input logic [DUTY_W-1:0] v);
        while ($urandom_range(99) < send_gap_pct) begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        kind = k;
        write_row = r;
        write_color = c;
        write_column = x;
        write_value = v;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_word();
        int                 pick;
        logic [ROW_W-1:0]   r;
        logic [COLOR_W-1:0] c;
        logic [COL_W-1:0]   x;
        logic [DUTY_W-1:0]  v;
        pick = $urandom_range(99);
        r = ROW_W'($urandom_range(7));
        c = COLOR_W'($urandom_range(3));
        x = COL_W'($urandom_range(15));
        v = DUTY_W'($urandom_range(255));
        if (pick < 58)
            send_word(KIND_TICK, r, c, x, v);
        else if (pick < 88) begin
            r = ROW_W'($urandom_range(SCAN_ROWS - 1));
            c = COLOR_W'($urandom_range(COLORS - 1));
            if ($urandom_range(4) == 0)
                v = '0;
            send_word(KIND_WRITE, r, c, x, v);
        end
        else if (pick < 91)
            send_word(KIND_FLASH, r, c, x, v);
        else if (pick < 96) begin
            if ($urandom_range(1) == 1)
                r = ROW_W'($urandom_range(7, SCAN_ROWS));
            else
                c = BAD_COLOR;
            send_word(KIND_WRITE, r, c, x, v);
        end
        else
            send_word(KIND_IGNORED, r, c, x, v);
    endtask

    task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic drain();
        item_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int i;
        rst_n = 1'b0;
        item_valid = 1'b0;
        kind = KIND_TICK;
        write_row = '0;
        write_color = '0;
        write_column = '0;
        write_value = '0;
        cfg_write = 1'b0;
        cfg_index = REG_MAIN_ENABLED;
        cfg_data = '0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(KIND_WRITE, 3'd0, 2'd0, 4'd0, 8'hff);
        send_word(KIND_WRITE, 3'd0, 2'd1, 4'd15, 8'h80);
        send_word(KIND_WRITE, ROW_W'(SCAN_ROWS - 1), COLOR_W'(COLORS - 1), 4'd15, 8'h01);
        send_word(KIND_WRITE, 3'd7, BAD_COLOR, 4'd15, 8'hff);
        send_word(KIND_WRITE, ROW_W'(SCAN_ROWS), 2'd0, 4'd0, 8'h7f);
        send_word(KIND_IGNORED, 3'd7, BAD_COLOR, 4'd15, 8'hff);
        send_word(KIND_FLASH, '0, '0, '0, '0);
        for (i = 0; i < SCAN_ROWS * COLORS + 1; i++)
            send_word(KIND_TICK, ROW_W'($urandom_range(7)), COLOR_W'($urandom_range(3)),
                      COL_W'($urandom_range(15)), DUTY_W'($urandom_range(255)));

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0:
                begin
                    cfg_word(REG_MAIN_ENABLED, 5'd1);
                    cfg_word(REG_MAIN_SPEED, 5'd1);
                    cfg_word(REG_UNDERGLOW_SPEED, 5'd16);
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    cfg_word(REG_MAIN_ENABLED, 5'd0);
                    cfg_word(REG_MAIN_SPEED, 5'd16);
                    cfg_word(REG_UNDERGLOW_SPEED, 5'd1);
                    send_gap_pct = 52;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    cfg_word(REG_MAIN_ENABLED, 5'd1);
                    cfg_word(REG_MAIN_SPEED, 5'd31);
                    cfg_word(REG_UNDERGLOW_SPEED, 5'd0);
                    send_gap_pct = 0;
                    recv_stall_pct = 52;
                end
                3:
                begin
                    cfg_word(REG_MAIN_ENABLED, 5'd30);
                    cfg_word(REG_MAIN_SPEED, 5'd0);
                    cfg_word(REG_UNDERGLOW_SPEED, 5'd31);
                    send_gap_pct = 7;
                    recv_stall_pct = 7;
                end
                4:
                begin
                    cfg_word(REG_MAIN_ENABLED, 5'd31);
                    cfg_word(REG_MAIN_SPEED, 5'd16);
                    cfg_word(REG_UNDERGLOW_SPEED, 5'd16);
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
                default:
                begin
                    cfg_word(REG_MAIN_ENABLED, CFG_W'($urandom_range(31)));
                    cfg_word(REG_MAIN_SPEED, CFG_W'($urandom_range(31)));
                    cfg_word(REG_UNDERGLOW_SPEED, CFG_W'($urandom_range(31)));
                    send_gap_pct = 0;
                    recv_stall_pct = 52;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
                send_random_word();
        end

        drain();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASS rgb_matrix_subframe_scanner");
        else
            $display("FAIL rgb_matrix_subframe_scanner");
        $finish;
    end

endmodule

### rgb_matrix_subframe_scanner.f
rtl/core/rmss_pkg.sv
rtl/core/rmss_ram.sv
rtl/core/rmss_frame_store.sv
rtl/core/rmss_scan_ctrl.sv
rtl/core/rgb_matrix_subframe_scanner.sv
rtl/core/rmss_checker.sv
verif/rmss_tb_pkg.sv
verif/tb_rgb_matrix_subframe_scanner.sv
